// ----- sv/fat12_cluster_table_engine_core_macros.svh -----
// Assertion macros for the FAT12 cluster table engine.
`ifndef FAT12_CLUSTER_TABLE_ENGINE_CORE_MACROS_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, disabled in reset.
`define FCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on clk, disabled in reset.
`define FCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define FCT_ASSERT_IMP(lbl, ante, cons)
`define FCT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/fctb_pkg.sv -----
// Shared types and constants for the FAT12 cluster table engine.
`timescale 1ns / 1ps
`default_nettype none

package fctb_pkg;

  // Table store size in bytes and its address width
  localparam int TABLE_BYTES = 8192;
  localparam int RAM_AW      = $clog2(TABLE_BYTES);

  // Field widths fixed by the interface
  localparam int ADDR_W  = 13;
  localparam int CLU_W   = 12;
  localparam int BYTE_W  = 8;

  // Entry codes
  localparam logic [CLU_W-1:0] END_MARK  = 12'hFFF;
  localparam logic [CLU_W-1:0] END_FIRST = 12'hFF8;
  localparam logic [CLU_W-1:0] FIRST_CLU = 12'd2;
  localparam logic [CLU_W-1:0] LIMIT_RST = 12'd4085;

  // Commands carried in the input tuser
  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_READ = 3'd1,
    CMD_GET  = 3'd2,
    CMD_MARK = 3'd3,
    CMD_FIND = 3'd4
  } fctb_cmd_t;

  // Results of the shared entry unit
  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] off1;
    logic              ok;
    logic [CLU_W-1:0]  entry;
    logic              chain_end;
    logic              zero;
    logic [BYTE_W-1:0] mark_lo;
    logic [BYTE_W-1:0] mark_hi;
    logic [CLU_W-1:0]  clu_inc;
  } fctb_unit_t;

endpackage

`default_nettype wire

// ----- sv/fat12_cluster_table_engine_core.sv -----
// Top level of the FAT12 cluster table engine: sequencer, table store and result register.
// One command is in flight at a time; in_tready is high only while the sequencer idles,
// and a finished result waits in the output register while the next command is taken.
// A load writes at accept, a read passes S_BYTE, a get passes S_ADDR, S_RD1 and S_RD2,
// and a mark adds S_WR1 to write the second byte; an out-of-range cluster goes from S_ADDR
// straight to S_DONE. Find free loops S_ADDR, S_RD1, S_RD2 per cluster examined. A result
// that still sits unaccepted in the output register when the next one is ready holds the
// sequencer in S_DONE until it is taken. The pace is set by the single read port of the
// byte store: each entry needs two byte reads through it plus the unpack step, and the
// free scan walks clusters one after another through that same path.
`timescale 1ns / 1ps
`default_nettype none
`include "fat12_cluster_table_engine_core_macros.svh"

module fat12_cluster_table_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: entry_limit
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  // Command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: byte_addr[12:0], byte_data[20:13], cluster[32:21], zero fill[39:33]
  input  wire logic [39:0] in_tdata,
  // tuser: cmd[2:0]
  input  wire logic [2:0]  in_tuser,
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: byte_out[7:0], entry_value[19:8], chain_end[20], free_cluster[32:21],
  //        status[33], zero fill[39:34]
  output logic [39:0]      out_tdata
);
  import fctb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_BYTE = 7'b0000010,
    S_ADDR = 7'b0000100,
    S_RD1  = 7'b0001000,
    S_RD2  = 7'b0010000,
    S_WR1  = 7'b0100000,
    S_DONE = 7'b1000000
  } fctb_state_t;

  fctb_state_t       state_r, state_nxt;
  fctb_cmd_t         cmd_r, cmd_nxt;
  logic [CLU_W-1:0]  limit_r;
  logic [CLU_W-1:0]  clu_r, clu_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic [ADDR_W-1:0] off1_r, off1_nxt;
  logic [BYTE_W-1:0] lo_r, lo_nxt;
  logic [BYTE_W-1:0] hi_r, hi_nxt;

  logic [BYTE_W-1:0] res_byte_r, res_byte_nxt;
  logic [CLU_W-1:0]  res_entry_r, res_entry_nxt;
  logic              res_end_r, res_end_nxt;
  logic [CLU_W-1:0]  res_free_r, res_free_nxt;
  logic              res_status_r, res_status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [39:0]       out_data_r, out_data_nxt;

  logic              in_fire;
  fctb_cmd_t         in_cmd;
  logic [ADDR_W-1:0] in_addr;
  logic [BYTE_W-1:0] in_byte;
  logic [CLU_W-1:0]  in_clu;
  logic              addr_ok;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  fctb_unit_t        unit;

  logic              mark_rd2;
  logic              load_fire;

  // Unpack the command transfer
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_cmd    = fctb_cmd_t'(in_tuser);
  assign in_addr   = in_tdata[12:0];
  assign in_byte   = in_tdata[20:13];
  assign in_clu    = in_tdata[32:21];
  assign addr_ok   = ({1'b0, in_addr} < (ADDR_W+1)'(TABLE_BYTES));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Table byte store
  fctb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[RAM_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared entry unit, always working on the current cluster
  fctb_entry_unit u_unit (
    .clu   (clu_r),
    .limit (limit_r),
    .lo    (lo_r),
    .hi    (ram_rdata),
    .res   (unit)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    clu_nxt        = clu_r;
    off_nxt        = off_r;
    off1_nxt       = off1_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_byte_nxt   = res_byte_r;
    res_entry_nxt  = res_entry_r;
    res_end_nxt    = res_end_r;
    res_free_nxt   = res_free_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_cmd;
          res_byte_nxt   = '0;
          res_entry_nxt  = '0;
          res_end_nxt    = 1'b0;
          res_free_nxt   = '0;
          res_status_nxt = 1'b0;
          case (in_cmd)
            CMD_LOAD: begin
              ram_we         = addr_ok;
              ram_waddr      = in_addr;
              ram_wdata      = in_byte;
              res_status_nxt = !addr_ok;
              state_nxt      = S_DONE;
            end
            CMD_READ: begin
              ram_re         = addr_ok;
              ram_raddr      = in_addr;
              res_status_nxt = !addr_ok;
              state_nxt      = addr_ok ? S_BYTE : S_DONE;
            end
            CMD_GET, CMD_MARK: begin
              clu_nxt   = in_clu;
              state_nxt = S_ADDR;
            end
            CMD_FIND: begin
              clu_nxt   = FIRST_CLU;
              state_nxt = S_ADDR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_BYTE: begin
        res_byte_nxt = ram_rdata;
        state_nxt    = S_DONE;
      end
      S_ADDR: begin
        // Check the cluster and fetch its first byte
        off_nxt  = unit.off;
        off1_nxt = unit.off1;
        if (unit.ok) begin
          ram_re    = 1'b1;
          ram_raddr = unit.off;
          state_nxt = S_RD1;
        end else begin
          res_status_nxt = (cmd_r != CMD_FIND);
          state_nxt      = S_DONE;
        end
      end
      S_RD1: begin
        // Capture the first byte, fetch the second
        lo_nxt    = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = off1_r;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        case (cmd_r)
          CMD_GET: begin
            res_entry_nxt = unit.entry;
            res_end_nxt   = unit.chain_end;
            state_nxt     = S_DONE;
          end
          CMD_MARK: begin
            ram_we    = 1'b1;
            ram_waddr = off_r;
            ram_wdata = unit.mark_lo;
            hi_nxt    = unit.mark_hi;
            state_nxt = S_WR1;
          end
          CMD_FIND: begin
            if (unit.zero) begin
              res_free_nxt = clu_r;
              state_nxt    = S_DONE;
            end else begin
              clu_nxt   = unit.clu_inc;
              state_nxt = S_ADDR;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = off1_r;
        ram_wdata = hi_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, res_status_r, res_free_r, res_end_r, res_entry_r,
                           res_byte_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    clu_r        <= clu_nxt;
    off_r        <= off_nxt;
    off1_r       <= off1_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_byte_r   <= res_byte_nxt;
    res_entry_r  <= res_entry_nxt;
    res_end_r    <= res_end_nxt;
    res_free_r   <= res_free_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Checks
  assign mark_rd2  = (state_r == S_RD2) && (cmd_r == CMD_MARK);
  assign load_fire = in_fire && (in_cmd == CMD_LOAD);

  `FCT_ASSERT_NXT(a_busy_after_accept, in_fire, !in_tready)
  `FCT_ASSERT_NXT(a_mark_second_write, mark_rd2, (state_r == S_WR1) && ram_we)
  `FCT_ASSERT_IMP(a_write_source, ram_we, (state_r == S_WR1) || mark_rd2 || load_fire)
  `FCT_ASSERT_IMP(a_chain_end_value, out_tvalid && out_tdata[20], out_tdata[19:8] >= END_FIRST)

endmodule

`default_nettype wire

// ----- sv/fctb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/fctb_entry_unit.sv -----
// Shared entry unit: byte offset, range check, entry unpack and end-of-chain merge.
`timescale 1ns / 1ps
`default_nettype none

module fctb_entry_unit (
  input  wire logic [11:0]        clu,
  input  wire logic [11:0]        limit,
  input  wire logic [7:0]         lo,
  input  wire logic [7:0]         hi,
  output fctb_pkg::fctb_unit_t    res
);
  import fctb_pkg::*;

  logic [ADDR_W-1:0] off;
  logic [ADDR_W:0]   off1_wide;
  logic              odd;
  logic [CLU_W-1:0]  entry;

  // Offset is clu * 3 / 2, i.e. clu + clu / 2
  assign off       = {1'b0, clu} + {2'b00, clu[CLU_W-1:1]};
  assign off1_wide = {1'b0, off} + {{ADDR_W{1'b0}}, 1'b1};
  assign odd       = clu[0];

  // Even entry is the low 12 bits of the pair, odd entry the high 12 bits
  assign entry = odd ? {hi, lo[7:4]} : {hi[3:0], lo};

  always_comb begin
    res           = '0;
    res.off       = off;
    res.off1      = off1_wide[ADDR_W-1:0];
    res.ok        = (clu < limit) && (off1_wide < (ADDR_W+1)'(TABLE_BYTES));
    res.entry     = entry;
    res.chain_end = (entry >= END_FIRST);
    res.zero      = (entry == '0);
    // Merge the end-of-chain code into the two bytes
    if (odd) begin
      res.mark_lo = {END_MARK[3:0], lo[3:0]};
      res.mark_hi = END_MARK[11:4];
    end else begin
      res.mark_lo = END_MARK[7:0];
      res.mark_hi = {hi[7:4], END_MARK[11:8]};
    end
    res.clu_inc   = clu + 12'd1;
  end

endmodule

`default_nettype wire

// ----- dv/tb_fat12_cluster_table_engine_core.sv -----
// Self-checking testbench for the FAT12 cluster table engine core.
`timescale 1ns / 1ps
`default_nettype none

module tb_fat12_cluster_table_engine_core;
  import fctb_pkg::*;

  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REGION_CLU     = 256;          // clusters 0..255 are preloaded
  localparam int REGION_BYTES   = 384;          // bytes that hold those clusters
  localparam int PHASE_ITEMS    = 65;
  localparam int PHASE_COUNT    = 6;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AT_RESULT = 500;

  // Codes outside the command set; the block answers them with zeros
  localparam logic [2:0] CMD_RSV5 = 3'd5;
  localparam logic [2:0] CMD_RSV6 = 3'd6;
  localparam logic [2:0] CMD_RSV7 = 3'd7;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [CLU_W-1:0]  cluster;
  } fat_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [CLU_W-1:0]  entry_value;
    logic              chain_end;
    logic [CLU_W-1:0]  free_cluster;
    logic              status;
  } fat_result_t;

  typedef struct packed {
    fat_cmd_t    op;
    logic        fixed;
    fat_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [11:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  fat12_cluster_table_engine_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the table, with a record of which bytes hold known data
  logic [BYTE_W-1:0] fat_bytes [TABLE_BYTES];
  bit                written   [TABLE_BYTES];
  logic [CLU_W-1:0]  entry_limit = LIMIT_RST;

  fat_result_t result_q  [$];
  int          far_addrs [$];
  dir_row_t    dir_rows  [$];

  int  errors, n_items, n_results, n_finds, n_hits, n_rejects, n_limits;
  int  burst_left = 8;
  bit  idle_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int entry_offset(int c);
    return (c * 3) / 2;
  endfunction

  function automatic bit entry_fits(int c);
    return entry_offset(c) + 1 < TABLE_BYTES;
  endfunction

  function automatic bit entry_known(int c);
    int off;
    off = entry_offset(c);
    return written[off] && written[off + 1];
  endfunction

  // Unpack one 12-bit entry from its little-endian byte pair
  function automatic logic [CLU_W-1:0] fat_entry(int c);
    int          off;
    logic [15:0] pair;
    off  = entry_offset(c);
    pair = {fat_bytes[off + 1], fat_bytes[off]};
    return c[0] ? pair[15:4] : pair[11:0];
  endfunction

  function automatic bit cluster_ok(int c);
    return c < int'(entry_limit) && entry_fits(c);
  endfunction

  // True when the command would read a byte that was never written
  function automatic bit touches_unwritten(fat_cmd_t op);
    int k;
    case (op.cmd)
      CMD_READ: return !written[op.addr];
      CMD_GET, CMD_MARK: return cluster_ok(int'(op.cluster)) && !entry_known(int'(op.cluster));
      CMD_FIND: begin
        k = int'(FIRST_CLU);
        while (k < int'(entry_limit) && entry_fits(k)) begin
          if (!entry_known(k)) return 1'b1;
          if (fat_entry(k) == '0) return 1'b0;
          k++;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Apply one command to the shadow table and return the result it gives
  function automatic fat_result_t fat_table_result(fat_cmd_t op);
    fat_result_t r;
    int          off;
    int          k;
    bit          found;
    r     = '0;
    off   = entry_offset(int'(op.cluster));
    found = 1'b0;
    case (op.cmd)
      CMD_LOAD: begin
        if (int'(op.addr) < TABLE_BYTES) begin
          fat_bytes[op.addr] = op.data;
          written[op.addr]   = 1'b1;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_READ: begin
        if (int'(op.addr) < TABLE_BYTES) r.byte_out = fat_bytes[op.addr];
        else r.status = 1'b1;
      end
      CMD_GET: begin
        if (cluster_ok(int'(op.cluster))) begin
          r.entry_value = fat_entry(int'(op.cluster));
          r.chain_end   = r.entry_value >= END_FIRST;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_MARK: begin
        if (!cluster_ok(int'(op.cluster))) begin
          r.status = 1'b1;
        end else if (!op.cluster[0]) begin
          fat_bytes[off]     = END_MARK[7:0];
          fat_bytes[off + 1] = {fat_bytes[off + 1][7:4], END_MARK[11:8]};
        end else begin
          fat_bytes[off]     = {END_MARK[3:0], fat_bytes[off][3:0]};
          fat_bytes[off + 1] = END_MARK[11:4];
        end
      end
      CMD_FIND: begin
        k = int'(FIRST_CLU);
        while (!found && k < int'(entry_limit) && entry_fits(k)) begin
          if (fat_entry(k) == '0) begin
            r.free_cluster = CLU_W'(k);
            found          = 1'b1;
          end
          k++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [2:0] cmd, int addr, int data, int clu, bit fixed,
                                      int bo, int ev, int ce, int fc, int st);
    dir_row_t row;
    row.op.cmd                = cmd;
    row.op.addr               = ADDR_W'(addr);
    row.op.data               = BYTE_W'(data);
    row.op.cluster            = CLU_W'(clu);
    row.fixed                 = fixed;
    row.want.byte_out         = BYTE_W'(bo);
    row.want.entry_value      = CLU_W'(ev);
    row.want.chain_end        = ce[0];
    row.want.free_cluster     = CLU_W'(fc);
    row.want.status           = st[0];
    return row;
  endfunction

  // Random command, biased to the preloaded region so most reads hit known data
  function automatic fat_cmd_t make_random_cmd();
    fat_cmd_t op;
    int       sel;
    op.cmd     = CMD_LOAD;
    op.addr    = ADDR_W'($urandom_range(0, TABLE_BYTES - 1));
    op.data    = BYTE_W'($urandom_range(0, 255));
    op.cluster = CLU_W'($urandom_range(0, 4095));
    sel        = $urandom_range(0, 99);
    if (sel < 30) begin
      if ($urandom_range(0, 3) != 0) op.addr = ADDR_W'($urandom_range(0, REGION_BYTES - 1));
      if ($urandom_range(0, 3) == 0) op.data = '0;
    end else if (sel < 45) begin
      op.cmd = CMD_READ;
      if (far_addrs.size() != 0 && $urandom_range(0, 3) == 0)
        op.addr = ADDR_W'(far_addrs[$urandom_range(0, far_addrs.size() - 1)]);
      else
        op.addr = ADDR_W'($urandom_range(0, REGION_BYTES - 1));
    end else if (sel < 83) begin
      op.cmd = (sel < 68) ? CMD_GET : CMD_MARK;
      case ($urandom_range(0, 5))
        0: ;
        1: op.cluster = CLU_W'($urandom_range(entry_limit, 4095));
        default: op.cluster = CLU_W'($urandom_range(0, REGION_CLU - 1));
      endcase
    end else if (sel < 95) begin
      op.cmd = CMD_FIND;
    end else begin
      op.cmd = 3'($urandom_range(CMD_RSV5, CMD_RSV7));
    end
    // Fall back to a load rather than read unknown table contents
    if (touches_unwritten(op)) op.cmd = CMD_LOAD;
    return op;
  endfunction

  // Offer one command, hold it until the transfer, then record its expected result
  task automatic send_cmd(input fat_cmd_t op, input bit fixed, input fat_result_t want);
    fat_result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= op.cmd;
    in_tdata  <= {7'b0, op.cluster, op.data, op.addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = fat_table_result(op);
    result_q.push_back(fixed ? want : r);
    n_items++;
    if (op.cmd == CMD_LOAD && int'(op.addr) >= REGION_BYTES) far_addrs.push_back(int'(op.addr));
    if (op.cmd == CMD_FIND) begin
      n_finds++;
      if (r.free_cluster != '0) n_hits++;
    end
    if (r.status) n_rejects++;
  endtask

  // Insert a random gap at the end of each burst while idle gaps are enabled
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  task automatic write_limit(input logic [11:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    entry_limit  = v;
    n_limits++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Result sink: check each transfer, then pick the next ready value
  initial begin : result_sink
    fat_result_t want;
    fat_result_t got;
    int          stall_left;
    int          mode;
    int          mode_left;
    stall_left = 0;
    mode       = 0;
    mode_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[19:8], out_tdata[20], out_tdata[32:21], out_tdata[33]};
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, tdata %h", $time, out_tdata);
        end else begin
          want = result_q.pop_front();
          check_field("byte_out", 16'(want.byte_out), 16'(got.byte_out));
          check_field("entry_value", 16'(want.entry_value), 16'(got.entry_value));
          check_field("chain_end", 16'(want.chain_end), 16'(got.chain_end));
          check_field("free_cluster", 16'(want.free_cluster), 16'(got.free_cluster));
          check_field("status", 16'(want.status), 16'(got.status));
        end
        n_results++;
        // Hold off long enough for the block to back up its input
        if (n_results == HOLD_AT_RESULT) stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left <= 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(40, 160);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    fat_cmd_t          op;
    dir_row_t          row;
    logic [CLU_W-1:0]  e0;
    logic [CLU_W-1:0]  e1;
    logic [BYTE_W-1:0] pb [3];
    logic [11:0]       lim;
    int                c;
    int                j;
    int                i;
    int                ph;

    // Directed rows: typed results where they are obvious, predictor elsewhere
    dir_rows.push_back(mk_row(CMD_LOAD, 0, 'hF0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LOAD, 1, 'hFF, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LOAD, 2, 'hFF, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LOAD, 3, 'h00, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LOAD, 4, 'h00, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LOAD, 5, 'h00, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_READ, 0, 0, 0, 1, 'hF0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_GET, 0, 0, 0, 1, 0, 'hFF0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_GET, 0, 0, 1, 1, 0, 'hFFF, 1, 0, 0));
    dir_rows.push_back(mk_row(CMD_FIND, 0, 0, 0, 1, 0, 0, 0, 2, 0));
    dir_rows.push_back(mk_row(CMD_MARK, 0, 0, 2, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_GET, 0, 0, 2, 1, 0, 'hFFF, 1, 0, 0));
    dir_rows.push_back(mk_row(CMD_READ, 4, 0, 0, 1, 'h0F, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_FIND, 0, 0, 0, 1, 0, 0, 0, 3, 0));
    dir_rows.push_back(mk_row(CMD_MARK, 0, 0, 3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LOAD, 8191, 'hFF, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_READ, 8191, 0, 0, 1, 'hFF, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LOAD, 6126, 'hF7, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_LOAD, 6127, 'hFF, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_GET, 0, 0, 4084, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_GET, 0, 0, 4085, 1, 0, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(CMD_MARK, 0, 0, 4095, 1, 0, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(CMD_RSV7, 8191, 'hFF, 4095, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_RSV6, 100, 'h5A, 100, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(CMD_RSV5, 0, 0, 0, 1, 0, 0, 0, 0, 0));

    // Reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_cmd(row.op, row.fixed, row.want);
      pace_sender();
    end

    // Preload clusters 0..255, roughly one entry in six left free
    for (c = 0; c < REGION_CLU; c += 2) begin
      e0 = '0;
      e1 = '0;
      if ($urandom_range(0, 5) != 0) e0 = CLU_W'($urandom_range(1, 4095));
      if ($urandom_range(0, 5) != 0) e1 = CLU_W'($urandom_range(1, 4095));
      pb[0] = e0[7:0];
      pb[1] = {e1[3:0], e0[11:8]};
      pb[2] = e1[11:4];
      for (j = 0; j < 3; j++) begin
        op.cmd     = CMD_LOAD;
        op.addr    = ADDR_W'((c * 3) / 2 + j);
        op.data    = pb[j];
        op.cluster = CLU_W'($urandom_range(0, 4095));
        send_cmd(op, 1'b0, '0);
        pace_sender();
      end
    end

    // Random phases, each under its own cluster limit
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: lim = FIRST_CLU;
        1: lim = CLU_W'(REGION_CLU);
        2: lim = CLU_W'($urandom_range(3, REGION_CLU));
        3: lim = FIRST_CLU + 12'd1;
        4: lim = LIMIT_RST;
        default: lim = CLU_W'($urandom_range(FIRST_CLU, LIMIT_RST));
      endcase
      write_limit(lim);
      idle_on = (ph != 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) wait_drained();
        send_cmd(make_random_cmd(), 1'b0, '0);
        pace_sender();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, result_q.size());
    end

    $display("Sent %0d commands under %0d limit settings, checked %0d results",
             n_items, n_limits, n_results);
    $display("Free scans %0d (%0d found a cluster), out-of-range answers %0d",
             n_finds, n_hits, n_rejects);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/fctb_pkg.sv
sv/fctb_ram.sv
sv/fctb_entry_unit.sv
sv/fat12_cluster_table_engine_core.sv
dv/tb_fat12_cluster_table_engine_core.sv
